[rtl/core/nau_pkg.sv]
package nau_pkg;

    // Field widths
    localparam int DATA_W       = 16;
    localparam int LAYER_W      = 3;
    localparam int MODE_W       = 2;
    localparam int CFG_W        = 16;

    // Defaults handed to the top level
    localparam int LAYER_COUNT_DEF = 8;

    // Tanh table geometry: segments of 1/16 over |z| in 0..4
    localparam int TANH_SEGMENTS  = 64;
    localparam int TABLE_SEGMENTS = 64;
    localparam int TANH_LIMIT     = (TANH_SEGMENTS < TABLE_SEGMENTS) ?
                                    TANH_SEGMENTS : TABLE_SEGMENTS;
    localparam int POINT_W        = 13;
    localparam int SEG_W          = 6;
    localparam int IDX_W          = 7;
    localparam int FRAC_W         = 8;
    localparam int DIFF_W         = 9;

    // 1.0 in Q4.12
    localparam int Q_ONE          = 4096;

    typedef logic [POINT_W-1:0] point_t;

    // round(4096 * tanh(k/16)), k = 0..64
    localparam point_t TANH_POINTS [0:TABLE_SEGMENTS] = '{
           0,  256,  509,  759, 1003, 1240, 1468, 1686,
        1893, 2088, 2272, 2443, 2602, 2748, 2883, 3007,
        3119, 3222, 3315, 3399, 3475, 3543, 3604, 3659,
        3707, 3751, 3790, 3825, 3856, 3883, 3908, 3929,
        3949, 3966, 3981, 3994, 4006, 4016, 4026, 4034,
        4041, 4048, 4053, 4058, 4063, 4067, 4070, 4073,
        4076, 4078, 4080, 4082, 4084, 4085, 4086, 4088,
        4089, 4089, 4090, 4091, 4091, 4092, 4092, 4093,
        4093
    };

    // Activation mode codes as stored per layer
    typedef enum logic [MODE_W-1:0] {
        MODE_LINEAR  = 2'd0,
        MODE_SIGMOID = 2'd1,
        MODE_TANH    = 2'd2,
        MODE_RELU    = 2'd3
    } mode_t;

    // Sideband that travels down the pipe with each beat
    typedef struct packed {
        mode_t                     mode;
        logic signed [DATA_W-1:0]  z;
        logic                      neg;
    } nau_side_t;

    // Table address and interpolation weight from the front stage
    typedef struct packed {
        logic              sat;
        logic [SEG_W-1:0]  seg;
        logic [FRAC_W-1:0] frac;
    } nau_tap_t;

endpackage

[rtl/core/nau_decode.sv]
module nau_decode #(
    parameter int LAYER_COUNT = nau_pkg::LAYER_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nau_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_accept,
    input  logic [nau_pkg::LAYER_W-1:0]         layer_sel,
    input  logic signed [nau_pkg::DATA_W-1:0]   pre_activation,
    output logic                                valid_q,
    output nau_pkg::nau_side_t                  side_q,
    output nau_pkg::nau_tap_t                   tap_q
);

    logic [nau_pkg::MODE_W-1:0]          modes_reg [LAYER_COUNT];
    nau_pkg::mode_t                      mode_sel;
    logic signed [nau_pkg::DATA_W-1:0]   arg;
    logic [nau_pkg::DATA_W-1:0]          arg_u;
    logic [nau_pkg::DATA_W-1:0]          mag;
    logic [7:0]                          seg_full;

    logic                                valid_reg;
    nau_pkg::nau_side_t                  side_reg;
    nau_pkg::nau_side_t                  side_next;
    nau_pkg::nau_tap_t                   tap_reg;
    nau_pkg::nau_tap_t                   tap_next;

    // Per-layer mode register, only the implemented layers are kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAYER_COUNT; i++)
            begin
                modes_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < LAYER_COUNT; i++)
            begin
                modes_reg[i] <= cfg_data[2*i +: nau_pkg::MODE_W];
            end
        end
    end

    // Mode lookup; layers beyond the implemented set pass through linear
    always_comb
    begin
        mode_sel = nau_pkg::MODE_LINEAR;
        for (int i = 0; i < LAYER_COUNT; i++)
        begin
            if (layer_sel == nau_pkg::LAYER_W'(i))
            begin
                mode_sel = nau_pkg::mode_t'(modes_reg[i]);
            end
        end
    end

    // Tanh argument: sigmoid uses z/2 (floor), then magnitude and segment
    always_comb
    begin
        arg      = (mode_sel == nau_pkg::MODE_SIGMOID) ? (pre_activation >>> 1)
                                                        : pre_activation;
        arg_u    = arg;
        mag      = arg_u[nau_pkg::DATA_W-1] ? (~arg_u + 16'd1) : arg_u;
        seg_full = mag[15:8];

        side_next.mode = mode_sel;
        side_next.z    = pre_activation;
        side_next.neg  = arg_u[nau_pkg::DATA_W-1];

        tap_next.sat   = (seg_full >= 8'(nau_pkg::TANH_LIMIT));
        tap_next.seg   = seg_full[nau_pkg::SEG_W-1:0];
        tap_next.frac  = mag[nau_pkg::FRAC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        tap_reg  <= tap_next;
    end

    assign valid_q = valid_reg;
    assign side_q  = side_reg;
    assign tap_q   = tap_reg;

endmodule

[rtl/core/nau_interp.sv]
module nau_interp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              valid_in,
    input  nau_pkg::nau_side_t                side_in,
    input  nau_pkg::nau_tap_t                 tap_in,
    output logic                              valid_q,
    output nau_pkg::nau_side_t                side_q,
    output nau_pkg::point_t                   lo_q,
    output logic [nau_pkg::DIFF_W-1:0]        step_q
);

    logic [nau_pkg::IDX_W-1:0]    idx_lo;
    logic [nau_pkg::IDX_W-1:0]    idx_hi;
    nau_pkg::point_t              pt_lo;
    nau_pkg::point_t              pt_hi;
    nau_pkg::point_t              lo_next;
    logic [nau_pkg::DIFF_W-1:0]   diff_next;
    logic [2*nau_pkg::DIFF_W-1:0] prod;

    // Stage 2 registers
    logic                         s2_valid_reg;
    nau_pkg::nau_side_t           s2_side_reg;
    nau_pkg::point_t              s2_lo_reg;
    logic [nau_pkg::DIFF_W-1:0]   s2_diff_reg;
    logic [nau_pkg::FRAC_W-1:0]   s2_frac_reg;

    // Stage 3 registers
    logic                         s3_valid_reg;
    nau_pkg::nau_side_t           s3_side_reg;
    nau_pkg::point_t              s3_lo_reg;
    logic [nau_pkg::DIFF_W-1:0]   s3_step_reg;

    // Table read at both ends of the segment; saturation forces 1.0 flat
    always_comb
    begin
        idx_lo = {1'b0, tap_in.seg};
        idx_hi = idx_lo + 7'd1;
        pt_lo  = nau_pkg::TANH_POINTS[idx_lo];
        pt_hi  = nau_pkg::TANH_POINTS[idx_hi];
        if (tap_in.sat)
        begin
            lo_next   = nau_pkg::POINT_W'(nau_pkg::Q_ONE);
            diff_next = '0;
        end
        else
        begin
            lo_next   = pt_lo;
            diff_next = nau_pkg::DIFF_W'(pt_hi - pt_lo);
        end
    end

    // Interpolation product, top bits kept (>> 8)
    assign prod = (2*nau_pkg::DIFF_W)'(s2_diff_reg * {1'b0, s2_frac_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= valid_in;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg <= side_in;
        s2_lo_reg   <= lo_next;
        s2_diff_reg <= diff_next;
        s2_frac_reg <= tap_in.frac;

        s3_side_reg <= s2_side_reg;
        s3_lo_reg   <= s2_lo_reg;
        s3_step_reg <= prod[nau_pkg::FRAC_W +: nau_pkg::DIFF_W];
    end

    assign valid_q = s3_valid_reg;
    assign side_q  = s3_side_reg;
    assign lo_q    = s3_lo_reg;
    assign step_q  = s3_step_reg;

endmodule

[rtl/core/nau_output.sv]
module nau_output (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               valid_in,
    input  nau_pkg::nau_side_t                 side_in,
    input  nau_pkg::point_t                    lo_in,
    input  logic [nau_pkg::DIFF_W-1:0]         step_in,
    output logic                               result_valid,
    output logic signed [nau_pkg::DATA_W-1:0]  activation_out
);

    nau_pkg::point_t                     ymag;
    logic [nau_pkg::POINT_W:0]           ysgn;
    logic [nau_pkg::POINT_W+1:0]         sig_sum;
    logic [nau_pkg::DATA_W-1:0]          out_next;

    logic                                out_valid_reg;
    logic [nau_pkg::DATA_W-1:0]          out_data_reg;

    // Finish tanh, then pick the result by mode
    always_comb
    begin
        ymag    = lo_in + nau_pkg::POINT_W'(step_in);
        ysgn    = side_in.neg ? ((~{1'b0, ymag}) + 14'd1) : {1'b0, ymag};
        sig_sum = 15'(nau_pkg::Q_ONE) + {ysgn[nau_pkg::POINT_W], ysgn};

        case (side_in.mode)
            nau_pkg::MODE_SIGMOID:
            begin
                out_next = {3'b000, sig_sum[nau_pkg::POINT_W:1]};
            end
            nau_pkg::MODE_TANH:
            begin
                out_next = {{2{ysgn[nau_pkg::POINT_W]}}, ysgn};
            end
            nau_pkg::MODE_RELU:
            begin
                out_next = (!side_in.z[nau_pkg::DATA_W-1] && (side_in.z != '0)) ?
                           side_in.z : '0;
            end
            default:
            begin
                out_next = side_in.z;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_next;
    end

    assign result_valid   = out_valid_reg;
    assign activation_out = out_data_reg;

endmodule

[rtl/core/neuron_activation_unit.sv]
// Neuron activation unit: applies the per-layer activation (linear, sigmoid,
// tanh or relu, chosen by a 2-bit field of layer_modes) to one signed Q4.12
// value. One beat is taken on every clock (busy stays low) and its result
// appears on activation_out with the result_valid strobe after passing
// through the four register stages: mode decode and |z|, tanh table read,
// interpolation multiply, sign and mode select. The result is shown for one
// cycle only; the receiver must take it then. layer_modes may be written
// (cfg_ready is always high) only when no beat is in the pipe.
module neuron_activation_unit #(
    parameter int LAYER_COUNT = nau_pkg::LAYER_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [nau_pkg::LAYER_W-1:0]        layer_sel,
    input  logic signed [nau_pkg::DATA_W-1:0]  pre_activation,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nau_pkg::CFG_W-1:0]          layer_modes,
    output logic                               result_valid,
    output logic signed [nau_pkg::DATA_W-1:0]  activation_out
);

    logic                          in_accept;
    logic                          cfg_we;

    logic                          s1_valid;
    nau_pkg::nau_side_t            s1_side;
    nau_pkg::nau_tap_t             s1_tap;

    logic                          s3_valid;
    nau_pkg::nau_side_t            s3_side;
    nau_pkg::point_t               s3_lo;
    logic [nau_pkg::DIFF_W-1:0]    s3_step;

    // Fully pipelined, never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_accept = start & ~busy;
    assign cfg_we    = cfg_valid & cfg_ready;

    nau_decode #(
        .LAYER_COUNT (LAYER_COUNT)
    ) u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (layer_modes),
        .in_accept      (in_accept),
        .layer_sel      (layer_sel),
        .pre_activation (pre_activation),
        .valid_q        (s1_valid),
        .side_q         (s1_side),
        .tap_q          (s1_tap)
    );

    nau_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (s1_valid),
        .side_in  (s1_side),
        .tap_in   (s1_tap),
        .valid_q  (s3_valid),
        .side_q   (s3_side),
        .lo_q     (s3_lo),
        .step_q   (s3_step)
    );

    nau_output u_output (
        .clk            (clk),
        .rst_n          (rst_n),
        .valid_in       (s3_valid),
        .side_in        (s3_side),
        .lo_in          (s3_lo),
        .step_in        (s3_step),
        .result_valid   (result_valid),
        .activation_out (activation_out)
    );

endmodule

[rtl/core/nau_checker.sv]
module nau_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic signed [nau_pkg::DATA_W-1:0]  pre_activation,
    input  logic                               result_valid,
    input  logic signed [nau_pkg::DATA_W-1:0]  activation_out
);

    // Every accepted beat is followed by its result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 result_valid)
        else $error("accepted beat produced no result after four cycles");

    // No result without a matching accepted beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 4))
        else $error("result strobe without an accepted beat");

    // Result is either the input itself, zero, or bounded by +-1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((activation_out == $past(pre_activation, 4)) ||
                          ((activation_out >= -16'sd4096) &&
                           (activation_out <= 16'sd4096))))
        else $error("activation out of range");

    // Zero input maps to zero, or to one half under sigmoid
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && ($past(pre_activation, 4) == 16'sd0)) |->
        ((activation_out == 16'sd0) || (activation_out == 16'sd2048)))
        else $error("zero input gave unexpected activation");

endmodule

bind neuron_activation_unit nau_checker u_nau_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int LAYER_COUNT  = nau_pkg::LAYER_COUNT_DEF;
    localparam int TANH_SEGS    = 64;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 100000;

    // round(4096 * tanh(k/16)), k = 0..64
    localparam int TANH_KNOTS [0:64] = '{
           0,  256,  509,  759, 1003, 1240, 1468, 1686,
        1893, 2088, 2272, 2443, 2602, 2748, 2883, 3007,
        3119, 3222, 3315, 3399, 3475, 3543, 3604, 3659,
        3707, 3751, 3790, 3825, 3856, 3883, 3908, 3929,
        3949, 3966, 3981, 3994, 4006, 4016, 4026, 4034,
        4041, 4048, 4053, 4058, 4063, 4067, 4070, 4073,
        4076, 4078, 4080, 4082, 4084, 4085, 4086, 4088,
        4089, 4089, 4090, 4091, 4091, 4092, 4092, 4093,
        4093
    };

    typedef enum logic {
        OP_VALUE,
        OP_MODES
    } op_kind_t;

    typedef struct {
        op_kind_t                          kind;
        logic [nau_pkg::LAYER_W-1:0]       layer;
        logic signed [nau_pkg::DATA_W-1:0] z;
        logic [nau_pkg::CFG_W-1:0]         modes;
        int unsigned                       gap;
    } stim_op_t;

    typedef struct {
        logic [nau_pkg::LAYER_W-1:0]       layer;
        logic signed [nau_pkg::DATA_W-1:0] z;
        nau_pkg::mode_t                    mode;
        logic signed [nau_pkg::DATA_W-1:0] act;
    } act_expect_t;

    logic                               clk            = 1'b0;
    logic                               rst_n          = 1'b0;
    logic                               start          = 1'b0;
    logic [nau_pkg::LAYER_W-1:0]        layer_sel      = '0;
    logic signed [nau_pkg::DATA_W-1:0]  pre_activation = '0;
    logic                               cfg_valid      = 1'b0;
    logic [nau_pkg::CFG_W-1:0]          layer_modes    = '0;
    logic                               busy;
    logic                               cfg_ready;
    logic                               result_valid;
    logic signed [nau_pkg::DATA_W-1:0]  activation_out;

    stim_op_t    stim_ops[$];
    act_expect_t pending_acts[$];
    logic [nau_pkg::CFG_W-1:0] modes_seen = '0;
    int unsigned hold_off      = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned cycle_count   = 0;
    int unsigned values_sent   = 0;
    int unsigned mode_writes   = 0;
    int unsigned mismatch_count = 0;

    neuron_activation_unit #(
        .LAYER_COUNT(LAYER_COUNT)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .layer_sel     (layer_sel),
        .pre_activation(pre_activation),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .layer_modes   (layer_modes),
        .result_valid  (result_valid),
        .activation_out(activation_out)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Table tanh in Q4.12, interpolated within each 1/16 segment, sign restored
    function automatic int tanh_q12(input int z);
        int mag;
        int seg;
        int y;
        mag = (z < 0) ? -z : z;
        seg = mag >> 8;
        if (seg >= TANH_SEGS)
            y = nau_pkg::Q_ONE;
        else
            y = TANH_KNOTS[seg] +
                (((TANH_KNOTS[seg + 1] - TANH_KNOTS[seg]) * (mag & 255)) >>> 8);
        return (z < 0) ? -y : y;
    endfunction

    function automatic logic signed [nau_pkg::DATA_W-1:0] activate_q12(
        input nau_pkg::mode_t                    mode,
        input logic signed [nau_pkg::DATA_W-1:0] z);
        int zi;
        int y;
        zi = z;
        case (mode)
            nau_pkg::MODE_SIGMOID: y = (nau_pkg::Q_ONE + tanh_q12(zi >>> 1)) >>> 1;
            nau_pkg::MODE_TANH:    y = tanh_q12(zi);
            nau_pkg::MODE_RELU:    y = (zi > 0) ? zi : 0;
            default:               y = zi;
        endcase
        return y[nau_pkg::DATA_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_value(input logic [nau_pkg::LAYER_W-1:0] layer,
                               input logic signed [nau_pkg::DATA_W-1:0] z,
                               input int unsigned gap);
        stim_op_t op;
        op.kind  = OP_VALUE;
        op.layer = layer;
        op.z     = z;
        op.modes = '0;
        op.gap   = gap;
        stim_ops.push_back(op);
    endtask

    task automatic queue_modes(input logic [nau_pkg::CFG_W-1:0] modes,
                               input int unsigned gap);
        stim_op_t op;
        op.kind  = OP_MODES;
        op.layer = '0;
        op.z     = '0;
        op.modes = modes;
        op.gap   = gap;
        stim_ops.push_back(op);
    endtask

    // Driver: presents queued beats, holds them while busy, idles for each beat's gap.
    // Mode writes wait until the pipe has drained.
    always @(posedge clk or negedge rst_n)
    begin : drive_beats
        stim_op_t                          op;
        logic                              start_nx;
        logic                              cfg_nx;
        logic [nau_pkg::LAYER_W-1:0]       layer_nx;
        logic signed [nau_pkg::DATA_W-1:0] z_nx;
        logic [nau_pkg::CFG_W-1:0]         modes_nx;
        if (!rst_n)
        begin
            start          <= 1'b0;
            cfg_valid      <= 1'b0;
            layer_sel      <= '0;
            pre_activation <= '0;
            layer_modes    <= '0;
        end
        else
        begin
            start_nx = start && busy;
            cfg_nx   = cfg_valid && !cfg_ready;
            layer_nx = layer_sel;
            z_nx     = pre_activation;
            modes_nx = layer_modes;

            if (start && !busy)
                quiet_cycles = 0;
            else if (quiet_cycles < DRAIN_CYCLES)
                quiet_cycles++;

            if (!start_nx && !cfg_nx)
            begin
                // junk on the data lines while nothing is offered
                layer_nx = nau_pkg::LAYER_W'($urandom);
                z_nx     = nau_pkg::DATA_W'($urandom);
                modes_nx = nau_pkg::CFG_W'($urandom);
                if (hold_off > 0)
                    hold_off--;
                else if (stim_ops.size() != 0)
                begin
                    op = stim_ops[0];
                    if (op.kind == OP_VALUE)
                    begin
                        start_nx = 1'b1;
                        layer_nx = op.layer;
                        z_nx     = op.z;
                        hold_off = op.gap;
                        void'(stim_ops.pop_front());
                    end
                    else if (quiet_cycles >= DRAIN_CYCLES && pending_acts.size() == 0)
                    begin
                        cfg_nx   = 1'b1;
                        modes_nx = op.modes;
                        hold_off = op.gap;
                        void'(stim_ops.pop_front());
                    end
                end
            end

            start          <= start_nx;
            cfg_valid      <= cfg_nx;
            layer_sel      <= layer_nx;
            pre_activation <= z_nx;
            layer_modes    <= modes_nx;
        end
    end

    // Monitor: predicts each accepted beat, checks each strobed result
    always @(posedge clk)
    begin : check_results
        act_expect_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                want.layer = layer_sel;
                want.z     = pre_activation;
                want.mode  = nau_pkg::MODE_LINEAR;
                if (layer_sel < LAYER_COUNT)
                    want.mode = nau_pkg::mode_t'(modes_seen[2*layer_sel +: nau_pkg::MODE_W]);
                want.act   = activate_q12(want.mode, pre_activation);
                pending_acts.push_back(want);
                values_sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                modes_seen = layer_modes;
                mode_writes++;
            end
            if (result_valid)
            begin
                if (pending_acts.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d", activation_out));
                else
                begin
                    want = pending_acts.pop_front();
                    if (activation_out !== want.act)
                        report_mismatch($sformatf(
                            "layer %0d mode %s z %0d: activation_out %0d, want %0d",
                            want.layer, want.mode.name(), want.z, activation_out, want.act));
                end
            end
        end
    end

    // Cycle limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out with %0d results outstanding", pending_acts.size());
        $display("Mismatches found");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin : run_main
        logic signed [nau_pkg::DATA_W-1:0] edge_z [4];
        logic [nau_pkg::CFG_W-1:0]         phase_modes;
        logic signed [nau_pkg::DATA_W-1:0] z;
        int                                pick;
        bit                                burst;

        edge_z = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};

        // reset value: every layer linear
        queue_value(3'd0, 16'sh7FFF, 0);
        queue_value(3'd7, 16'sh8000, 0);
        queue_value(3'd3, 16'sh0001, 1);

        // layers 0..7: linear, sigmoid, tanh, relu, repeated
        queue_modes(16'hE4E4, 0);
        foreach (edge_z[i])
        begin
            queue_value(3'd1, edge_z[i], 0);
            queue_value(3'd2, edge_z[i], 0);
            queue_value(3'd3, edge_z[i], 0);
        end
        queue_value(3'd4, 16'sh8000, 0);
        // tanh segment edges and the point of saturation
        queue_value(3'd6, 16'sd255, 0);
        queue_value(3'd6, 16'sd256, 2);
        queue_value(3'd6, -16'sd256, 0);
        queue_value(3'd6, 16'sd16383, 0);
        queue_value(3'd6, 16'sd16384, 3);
        queue_value(3'd6, -16'sd16384, 0);
        queue_value(3'd6, -16'sd16385, 0);
        // sigmoid halving of odd and negative values
        queue_value(3'd5, 16'sd32766, 0);
        queue_value(3'd5, -16'sd32767, 1);
        queue_value(3'd5, -16'sd3, 0);

        // random phases, each under its own mode setting
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:       phase_modes = 16'h0000;
                1:       phase_modes = 16'hFFFF;
                2:       phase_modes = 16'h5555;
                3:       phase_modes = 16'hAAAA;
                default: phase_modes = nau_pkg::CFG_W'($urandom);
            endcase
            burst = ($urandom_range(0, 3) == 0);
            queue_modes(phase_modes, $urandom_range(0, 8));
            for (int n = 0; n < 100; n++)
            begin
                pick = $urandom_range(0, 7);
                if (pick < 4)
                    z = nau_pkg::DATA_W'($urandom);
                else if (pick < 7)
                    z = nau_pkg::DATA_W'(int'($urandom_range(0, 34000)) - 17000);
                else
                    z = edge_z[$urandom_range(0, 3)];
                queue_value(nau_pkg::LAYER_W'($urandom_range(0, 7)), z,
                            burst ? 0 : $urandom_range(0, 8));
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_ops.size() != 0 || start || cfg_valid || pending_acts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d activations under %0d layer-mode settings,",
                 values_sent, mode_writes);
        $display("covering all four modes on every layer, with and without idle gaps");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
